FILE: sv/mqttp_pkg.sv
`timescale 1ns / 1ps

package mqttp_pkg;

  localparam int MAX_LENGTH_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int LENGTH_BITS = 28;
  localparam logic [7:0] TOPIC_LIMIT_RESET = 8'd31;

  localparam logic [1:0] ROLE_TOPIC = 2'd0;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd1;
  localparam logic [1:0] ROLE_SUMMARY = 2'd2;

  localparam logic [3:0] KIND_CONNACK = 4'd0;
  localparam logic [3:0] KIND_PUBLISH = 4'd1;
  localparam logic [3:0] KIND_PUBACK = 4'd2;
  localparam logic [3:0] KIND_PUBREC = 4'd3;
  localparam logic [3:0] KIND_PUBREL = 4'd4;
  localparam logic [3:0] KIND_PUBCOMP = 4'd5;
  localparam logic [3:0] KIND_SUBACK = 4'd6;
  localparam logic [3:0] KIND_UNSUBACK = 4'd7;
  localparam logic [3:0] KIND_PINGRESP = 4'd8;
  localparam logic [3:0] KIND_NONE = 4'd15;

  localparam logic [3:0] HDR_CONNACK = 4'h2;
  localparam logic [3:0] HDR_PUBLISH = 4'h3;
  localparam logic [3:0] HDR_PUBACK = 4'h4;
  localparam logic [3:0] HDR_PUBREC = 4'h5;
  localparam logic [3:0] HDR_PUBREL = 4'h6;
  localparam logic [3:0] HDR_PUBCOMP = 4'h7;
  localparam logic [3:0] HDR_SUBACK = 4'h9;
  localparam logic [3:0] HDR_UNSUBACK = 4'hb;
  localparam logic [3:0] HDR_PINGRESP = 4'hd;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_PUBACK = 2'd1;
  localparam logic [1:0] REPLY_PUBREC = 2'd2;
  localparam logic [1:0] REPLY_PUBCOMP = 2'd3;

  localparam logic [1:0] QOS_0 = 2'd0;
  localparam logic [1:0] QOS_1 = 2'd1;
  localparam logic [1:0] QOS_2 = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             role;
    logic [7:0]             out_byte;
    logic [3:0]             packet_kind;
    logic [15:0]            packet_id;
    logic [7:0]             return_code;
    logic [1:0]             qos;
    logic                   dup;
    logic [LENGTH_BITS-1:0] payload_length;
    logic [1:0]             reply_kind;
    logic                   connected;
    logic                   malformed;
    logic                   last_of_run;
  } out_item_t;

  typedef struct packed {
    logic byte_valid;
    logic sum_valid;
  } push_t;

  function automatic logic [3:0] kind_of(input logic [7:0] hdr);
    logic [3:0] k;
    case (hdr[7:4])
      HDR_CONNACK: k = KIND_CONNACK;
      HDR_PUBLISH: k = KIND_PUBLISH;
      HDR_PUBACK: k = KIND_PUBACK;
      HDR_PUBREC: k = KIND_PUBREC;
      HDR_PUBREL: k = KIND_PUBREL;
      HDR_PUBCOMP: k = KIND_PUBCOMP;
      HDR_SUBACK: k = KIND_SUBACK;
      HDR_UNSUBACK: k = KIND_UNSUBACK;
      HDR_PINGRESP: k = KIND_PINGRESP;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/mqttp_parse.sv
`timescale 1ns / 1ps

module mqttp_parse #(
  parameter int MAX_LENGTH_BYTES = mqttp_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  mqttp_pkg::in_item_t  in_data,
  input  logic [7:0]           topic_byte_limit,
  output mqttp_pkg::push_t     push,
  output mqttp_pkg::out_item_t byte_item,
  output mqttp_pkg::out_item_t sum_item
);
  import mqttp_pkg::*;

  localparam logic [2:0] MAX_LB = 3'(MAX_LENGTH_BYTES);
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  phase_t                 phase, phase_step, phase_next;
  logic [7:0]             header_byte, header_byte_next;
  logic [LENGTH_BITS-1:0] remaining_length, remaining_length_next;
  logic [2:0]             length_byte_count, length_byte_count_next;
  logic [LENGTH_BITS-1:0] body_byte_count, body_byte_count_next;
  logic [15:0]            topic_length, topic_length_next;
  logic [15:0]            id_value, id_value_next;
  logic [7:0]             code_value, code_value_next;
  logic [2:0]             frame_byte_count, frame_byte_count_next;
  logic                   length_error, length_error_next;
  logic                   link_connected, link_connected_next;

  logic [7:0]             b;
  logic [3:0]             body_kind;
  logic [1:0]             body_qos;
  logic [LENGTH_BITS-1:0] idx;
  logic [LENGTH_BITS-1:0] topic_end;
  logic [LENGTH_BITS-1:0] limit_end;
  logic [LENGTH_BITS-1:0] group;
  logic                   emit_byte;
  logic [1:0]             emit_role;

  logic [3:0]             kind;
  logic [1:0]             sum_qos;
  logic [17:0]            need;
  logic                   bad;
  logic                   emit_sum;

  assign b = in_data.rx_byte;
  assign body_kind = kind_of(header_byte);
  assign body_qos = header_byte[2:1];
  assign idx = body_byte_count;
  assign topic_end = LENGTH_BITS'({1'b0, topic_length} + 17'd2);
  assign limit_end = LENGTH_BITS'({2'b0, topic_byte_limit} + 10'd2);
  assign group = LENGTH_BITS'(b[6:0]);

  // Next phase.
  always_comb begin
    phase_step = phase;
    case (phase)
      PH_HEADER: phase_step = PH_LENGTH;
      PH_LENGTH: begin
        if (!b[7]) begin
          phase_step = PH_BODY;
        end else if (length_byte_count + 3'd1 >= MAX_LB) begin
          phase_step = PH_SKIP;
        end
      end
      default: phase_step = phase;
    endcase
    phase_next = phase;
    if (accept) begin
      phase_next = in_data.frame_last ? PH_HEADER : phase_step;
    end
  end

  // Frame datapath for the accepted byte.
  always_comb begin
    header_byte_next = header_byte;
    remaining_length_next = remaining_length;
    length_byte_count_next = length_byte_count;
    body_byte_count_next = body_byte_count;
    topic_length_next = topic_length;
    id_value_next = id_value;
    code_value_next = code_value;
    frame_byte_count_next = frame_byte_count;
    length_error_next = length_error;
    emit_byte = 1'b0;
    emit_role = ROLE_TOPIC;
    if (phase == PH_HEADER) begin
      header_byte_next = b;
      remaining_length_next = '0;
      length_byte_count_next = '0;
      body_byte_count_next = '0;
      topic_length_next = '0;
      id_value_next = '0;
      code_value_next = '0;
      length_error_next = 1'b0;
      frame_byte_count_next = 3'd1;
    end else begin
      if (frame_byte_count != 3'd7) begin
        frame_byte_count_next = frame_byte_count + 3'd1;
      end
      case (phase)
        PH_LENGTH: begin
          if (length_byte_count < MAX_LB) begin
            case (length_byte_count[1:0])
              2'd0: remaining_length_next = remaining_length | group;
              2'd1: remaining_length_next = remaining_length | (group << 7);
              2'd2: remaining_length_next = remaining_length | (group << 14);
              default: remaining_length_next = remaining_length | (group << 21);
            endcase
          end
          length_byte_count_next = length_byte_count + 3'd1;
          if (b[7] && (length_byte_count_next >= MAX_LB)) begin
            length_error_next = 1'b1;
          end
        end
        PH_BODY: begin
          if (body_byte_count != COUNT_MAX) begin
            body_byte_count_next = body_byte_count + 1'b1;
          end
          if (idx < remaining_length) begin
            if (body_kind == KIND_PUBLISH) begin
              if (idx == '0) begin
                topic_length_next = {b, 8'h00};
              end else if (idx == LENGTH_BITS'(1)) begin
                topic_length_next = {topic_length[15:8], b};
              end else if (idx < topic_end) begin
                if (idx < limit_end) begin
                  emit_byte = 1'b1;
                  emit_role = ROLE_TOPIC;
                end
              end else if ((body_qos != QOS_0) && (idx == topic_end)) begin
                id_value_next = {b, 8'h00};
              end else if ((body_qos != QOS_0) && (idx == topic_end + 1'b1)) begin
                id_value_next = {id_value[15:8], b};
              end else begin
                emit_byte = 1'b1;
                emit_role = ROLE_PAYLOAD;
              end
            end else begin
              if (idx == '0) begin
                id_value_next = {b, 8'h00};
              end else if (idx == LENGTH_BITS'(1)) begin
                id_value_next = {id_value[15:8], b};
                if (body_kind == KIND_CONNACK) begin
                  code_value_next = b;
                end
              end else if ((idx == LENGTH_BITS'(2)) && (body_kind == KIND_SUBACK)) begin
                code_value_next = b;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result items.
  always_comb begin
    kind = kind_of(header_byte_next);
    sum_qos = header_byte_next[2:1];
    need = {2'b00, topic_length_next} + 18'd2 + ((sum_qos != QOS_0) ? 18'd2 : 18'd0);
    link_connected_next = link_connected;
    bad = length_error_next || (phase_step != PH_BODY) ||
          (body_byte_count_next != remaining_length_next);
    emit_sum = accept && in_data.frame_last && (kind != KIND_NONE) &&
               ((frame_byte_count_next >= 3'd4) || (kind == KIND_PINGRESP));

    sum_item = '0;
    sum_item.role = ROLE_SUMMARY;
    sum_item.packet_kind = kind;
    sum_item.packet_id = id_value_next;
    sum_item.last_of_run = 1'b1;
    case (kind)
      KIND_PUBLISH: begin
        sum_item.qos = sum_qos;
        sum_item.dup = header_byte_next[3];
        if (remaining_length_next >= LENGTH_BITS'(need)) begin
          sum_item.payload_length = remaining_length_next - LENGTH_BITS'(need);
        end else begin
          bad = 1'b1;
        end
        if (sum_qos == QOS_0) begin
          sum_item.packet_id = '0;
        end
        if (sum_qos == QOS_1) begin
          sum_item.reply_kind = REPLY_PUBACK;
        end
        if (sum_qos == QOS_2) begin
          sum_item.reply_kind = REPLY_PUBREC;
        end
      end
      KIND_CONNACK: begin
        if (remaining_length_next != LENGTH_BITS'(2)) begin
          bad = 1'b1;
        end
        sum_item.return_code = code_value_next;
        sum_item.packet_id = '0;
        if (emit_sum) begin
          link_connected_next = (code_value_next == 8'd0);
        end
      end
      KIND_SUBACK: begin
        if (remaining_length_next < LENGTH_BITS'(3)) begin
          bad = 1'b1;
        end
        sum_item.return_code = code_value_next;
      end
      KIND_PINGRESP: begin
        if (remaining_length_next != '0) begin
          bad = 1'b1;
        end
        sum_item.packet_id = '0;
      end
      default: begin
        if (remaining_length_next != LENGTH_BITS'(2)) begin
          bad = 1'b1;
        end
        if (kind == KIND_PUBREL) begin
          sum_item.reply_kind = REPLY_PUBCOMP;
        end
      end
    endcase
    sum_item.connected = link_connected_next;
    sum_item.malformed = bad;

    byte_item = '0;
    byte_item.role = emit_role;
    byte_item.out_byte = b;
    byte_item.last_of_run = !emit_sum;

    push.byte_valid = accept && emit_byte;
    push.sum_valid = emit_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      frame_byte_count <= '0;
      link_connected <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        frame_byte_count <= in_data.frame_last ? 3'd0 : frame_byte_count_next;
        link_connected <= link_connected_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header_byte <= header_byte_next;
      remaining_length <= remaining_length_next;
      length_byte_count <= length_byte_count_next;
      body_byte_count <= body_byte_count_next;
      topic_length <= topic_length_next;
      id_value <= id_value_next;
      code_value <= code_value_next;
      length_error <= length_error_next;
    end
  end

endmodule

FILE: sv/mqttp_out_queue.sv
`timescale 1ns / 1ps

module mqttp_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  mqttp_pkg::push_t     push,
  input  mqttp_pkg::out_item_t byte_item,
  input  mqttp_pkg::out_item_t sum_item,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mqttp_pkg::out_item_t out_data
);
  import mqttp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] sum_ptr;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_data = slots[rd_ptr];
  assign pop = out_valid && out_ready;
  assign room = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign sum_ptr = push.byte_valid ? wr_ptr + 1'b1 : wr_ptr;

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.byte_valid) + PTR_W'(push.sum_valid);
    count_next = count + CNT_W'(push.byte_valid) + CNT_W'(push.sum_valid) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.byte_valid) begin
      slots[wr_ptr] <= byte_item;
    end
    if (push.sum_valid) begin
      slots[sum_ptr] <= sum_item;
    end
  end

endmodule

FILE: sv/mqtt_rx_packet_parser.sv
`timescale 1ns / 1ps

// Receive-side MQTT control packet parser.
// The input channel (in_valid, in_ready, in_data) carries one received byte
// per item, with frame_last set on the last byte of a frame. The output
// channel (out_valid, out_ready, out_data) carries topic bytes, payload bytes
// and one packet summary at the end of each recognized frame.
// A byte is parsed in the cycle it is accepted, and its results are
// registered in the result queue. One byte is accepted every cycle while the
// four-entry result queue has room for two items, so the rate is one byte
// per cycle when the receiver keeps up; a byte that closes a frame and also
// carries a payload byte produces two items in the queue.
// When the receiver stalls, the queue holds up to four items; in_ready drops
// as soon as three items wait and rises again once no more than two remain.
// cfg_we writes cfg_wdata into the topic byte limit; write it only while idle.
// Reset empties the queue, sets the parser to expect a header byte, clears
// the connected flag and sets the topic byte limit to 31.
module mqtt_rx_packet_parser #(
  parameter int MAX_LENGTH_BYTES = mqttp_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mqttp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mqttp_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);
  import mqttp_pkg::*;

  logic       accept;
  logic [7:0] topic_byte_limit;
  push_t      push;
  out_item_t  byte_item;
  out_item_t  sum_item;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      topic_byte_limit <= TOPIC_LIMIT_RESET;
    end else if (cfg_we) begin
      topic_byte_limit <= cfg_wdata;
    end
  end

  mqttp_parse #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .in_data(in_data),
    .topic_byte_limit(topic_byte_limit),
    .push(push),
    .byte_item(byte_item),
    .sum_item(sum_item)
  );

  mqttp_out_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .byte_item(byte_item),
    .sum_item(sum_item),
    .room(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

`ifndef NO_ASSERTIONS
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (push.byte_valid || push.sum_valid) |-> accept)
    else $error("result pushed without an accepted item");

  a_summary_on_frame_end: assert property (@(posedge clk) disable iff (rst)
    push.sum_valid |-> in_data.frame_last && sum_item.role == ROLE_SUMMARY)
    else $error("summary outside the end of a frame");

  a_byte_not_summary: assert property (@(posedge clk) disable iff (rst)
    push.byte_valid |-> byte_item.role != ROLE_SUMMARY &&
                        byte_item.last_of_run == !push.sum_valid)
    else $error("byte result carries wrong role or run marker");

  a_out_drops_after_take: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(out_valid)) |-> $past(out_ready))
    else $error("output item lost without handshake");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mqttp_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PHASE_BYTES = 200;
  localparam logic [27:0] LEN_MAX = 28'hfffffff;

  typedef struct {
    logic       pinned;
    out_item_t  want;
  } pin_entry_t;

  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_last;
    logic       pinned;
    out_item_t  want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  out_item_t  pending_results [$];
  pin_entry_t offered_pins [$];
  stim_row_t  directed_rows [$];
  logic [7:0] frame_buf [$];

  int mismatch_count = 0;
  int bytes_sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  logic [7:0]  topic_limit;
  phase_t      ph;
  logic [7:0]  hdr;
  logic [27:0] rem_len;
  logic [2:0]  len_count;
  logic [27:0] body_count;
  logic [15:0] topic_size;
  logic [15:0] id_val;
  logic [7:0]  code_val;
  logic [2:0]  frame_count;
  logic        link_up;
  logic        len_err;

  mqtt_rx_packet_parser u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [3:0] header_kind(input logic [7:0] h);
    case (h[7:4])
      HDR_CONNACK: return KIND_CONNACK;
      HDR_PUBLISH: return KIND_PUBLISH;
      HDR_PUBACK: return KIND_PUBACK;
      HDR_PUBREC: return KIND_PUBREC;
      HDR_PUBREL: return KIND_PUBREL;
      HDR_PUBCOMP: return KIND_PUBCOMP;
      HDR_SUBACK: return KIND_SUBACK;
      HDR_UNSUBACK: return KIND_UNSUBACK;
      HDR_PINGRESP: return KIND_PINGRESP;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic out_item_t data_item(input logic [1:0] role, input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.role = role;
    r.out_byte = b;
    return r;
  endfunction

  function automatic out_item_t summary_item(input logic [3:0] kind, input logic [15:0] id,
                                             input logic [7:0] code, input logic [1:0] q,
                                             input logic dup, input logic [27:0] plen,
                                             input logic [1:0] reply, input logic conn,
                                             input logic bad);
    out_item_t r;
    r = '0;
    r.role = ROLE_SUMMARY;
    r.packet_kind = kind;
    r.packet_id = id;
    r.return_code = code;
    r.qos = q;
    r.dup = dup;
    r.payload_length = plen;
    r.reply_kind = reply;
    r.connected = conn;
    r.malformed = bad;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  task automatic clear_frame();
    hdr = '0;
    rem_len = '0;
    len_count = '0;
    body_count = '0;
    topic_size = '0;
    id_val = '0;
    code_val = '0;
    len_err = 1'b0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b, input logic last, input logic pin,
                               input out_item_t want);
    out_item_t   res [2];
    int          n;
    int          i;
    logic [3:0]  kind;
    logic [31:0] idx;
    logic [31:0] t;
    logic [31:0] need;
    logic [1:0]  q;
    logic [1:0]  reply;
    logic [15:0] id;
    logic [7:0]  code;
    logic [27:0] plen;
    logic        bad;
    n = 0;
    if (ph == PH_HEADER) begin
      clear_frame();
      hdr = b;
      frame_count = 3'd1;
      ph = PH_LENGTH;
    end else begin
      if (frame_count < 3'd7) frame_count++;
      if (ph == PH_LENGTH) begin
        if (len_count < 3'd4) rem_len = rem_len | ({21'd0, b[6:0]} << (7 * len_count));
        len_count++;
        if (b[7]) begin
          if (len_count >= 3'd4) begin
            len_err = 1'b1;
            ph = PH_SKIP;
          end
        end else begin
          ph = PH_BODY;
        end
      end else if (ph == PH_BODY) begin
        idx = {4'd0, body_count};
        if (body_count < LEN_MAX) body_count++;
        if (idx < {4'd0, rem_len}) begin
          kind = header_kind(hdr);
          if (kind == KIND_PUBLISH) begin
            if (idx == 0) begin
              topic_size = {b, 8'h00};
            end else if (idx == 1) begin
              topic_size[7:0] = b;
            end else begin
              t = idx - 32'd2;
              if (t < {16'd0, topic_size}) begin
                if (t < {24'd0, topic_limit}) begin
                  res[n] = data_item(ROLE_TOPIC, b);
                  n++;
                end
              end else begin
                t = t - {16'd0, topic_size};
                if (hdr[2:1] != QOS_0 && t == 0) begin
                  id_val = {b, 8'h00};
                end else if (hdr[2:1] != QOS_0 && t == 1) begin
                  id_val[7:0] = b;
                end else begin
                  res[n] = data_item(ROLE_PAYLOAD, b);
                  n++;
                end
              end
            end
          end else begin
            if (idx == 0) begin
              id_val = {b, 8'h00};
            end else if (idx == 1) begin
              id_val[7:0] = b;
              if (kind == KIND_CONNACK) code_val = b;
            end else if (idx == 2 && kind == KIND_SUBACK) begin
              code_val = b;
            end
          end
        end
      end
    end

    if (last) begin
      kind = header_kind(hdr);
      if (kind != KIND_NONE && (frame_count >= 3'd4 || kind == KIND_PINGRESP)) begin
        bad = len_err || ph != PH_BODY || body_count != rem_len;
        q = QOS_0;
        plen = '0;
        reply = REPLY_NONE;
        id = id_val;
        code = '0;
        case (kind)
          KIND_PUBLISH: begin
            q = hdr[2:1];
            need = 32'd2 + {16'd0, topic_size} + ((q != QOS_0) ? 32'd2 : 32'd0);
            if ({4'd0, rem_len} >= need) plen = 28'({4'd0, rem_len} - need);
            else bad = 1'b1;
            if (q == QOS_0) id = '0;
            if (q == QOS_1) reply = REPLY_PUBACK;
            if (q == QOS_2) reply = REPLY_PUBREC;
          end
          KIND_CONNACK: begin
            if (rem_len != 28'd2) bad = 1'b1;
            code = code_val;
            id = '0;
            link_up = (code_val == 8'd0);
          end
          KIND_SUBACK: begin
            if (rem_len < 28'd3) bad = 1'b1;
            code = code_val;
          end
          KIND_PINGRESP: begin
            if (rem_len != 28'd0) bad = 1'b1;
            id = '0;
          end
          default: begin
            if (rem_len != 28'd2) bad = 1'b1;
            if (kind == KIND_PUBREL) reply = REPLY_PUBCOMP;
          end
        endcase
        res[n] = summary_item(kind, id, code, q, (kind == KIND_PUBLISH) ? hdr[3] : 1'b0,
                              plen, reply, link_up, bad);
        n++;
      end
      ph = PH_HEADER;
      frame_count = '0;
    end

    if (n > 0) begin
      res[n - 1].last_of_run = 1'b1;
      if (pin) res[n - 1] = want;
    end
    for (i = 0; i < n; i++) pending_results.push_back(res[i]);
  endtask

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_v);
    if (got !== exp_v) report($sformatf("%s got %0h, expected %0h", name, got, exp_v));
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t exp_v);
    check_field("role", got.role, exp_v.role);
    check_field("out_byte", got.out_byte, exp_v.out_byte);
    check_field("packet_kind", got.packet_kind, exp_v.packet_kind);
    check_field("packet_id", got.packet_id, exp_v.packet_id);
    check_field("return_code", got.return_code, exp_v.return_code);
    check_field("qos", got.qos, exp_v.qos);
    check_field("dup", got.dup, exp_v.dup);
    check_field("payload_length", got.payload_length, exp_v.payload_length);
    check_field("reply_kind", got.reply_kind, exp_v.reply_kind);
    check_field("connected", got.connected, exp_v.connected);
    check_field("malformed", got.malformed, exp_v.malformed);
    check_field("last_of_run", got.last_of_run, exp_v.last_of_run);
  endtask

  always @(posedge clk) begin : monitor
    pin_entry_t p;
    if (!rst && in_valid && in_ready) begin
      p.pinned = 1'b0;
      p.want = '0;
      if (offered_pins.size() != 0) p = offered_pins.pop_front();
      parse_rx_byte(in_data.rx_byte, in_data.frame_last, p.pinned, p.want);
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) report("result with no expectation waiting");
      else compare_result(out_data, pending_results.pop_front());
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic pin,
                           input out_item_t want);
    int         gap;
    pin_entry_t p;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.pinned = pin;
    p.want = want;
    offered_pins.push_back(p);
    in_valid <= 1'b1;
    in_data <= {b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1, 1'b0, '0);
  endtask

  task automatic wait_idle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    @(negedge clk);
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      report($sformatf("%0d expected results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    topic_limit = v;
  endtask

  task automatic build_good_frame();
    logic [7:0] body [$];
    logic [7:0] len_bytes [$];
    logic [3:0] tcode;
    logic [3:0] low;
    logic [7:0] lb;
    int         tl;
    int         rl;
    int         n;
    int         i;
    low = 4'($urandom);
    case ($urandom_range(0, 11))
      0: tcode = HDR_CONNACK;
      1: tcode = HDR_PUBACK;
      2: tcode = HDR_PUBREC;
      3: tcode = HDR_PUBREL;
      4: tcode = HDR_PUBCOMP;
      5: tcode = HDR_SUBACK;
      6: tcode = HDR_UNSUBACK;
      7: tcode = HDR_PINGRESP;
      default: tcode = HDR_PUBLISH;
    endcase
    case (tcode)
      HDR_CONNACK: begin
        body.push_back(8'($urandom_range(0, 1)));
        body.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
      end
      HDR_PINGRESP: begin
      end
      HDR_PUBLISH: begin
        n = $urandom_range(0, 99);
        if (n < 70) tl = $urandom_range(0, 12);
        else if (n < 97) tl = $urandom_range(0, 40);
        else tl = $urandom_range(100, 300);
        body.push_back(8'(tl >> 8));
        body.push_back(8'(tl));
        repeat (tl) body.push_back(8'($urandom));
        if (low[2:1] != QOS_0) repeat (2) body.push_back(8'($urandom));
        repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
      end
      default: begin
        repeat (2) body.push_back(8'($urandom));
        if (tcode == HDR_SUBACK) repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      end
    endcase
    rl = body.size();
    do begin
      lb = 8'(rl & 'h7f);
      rl = rl >> 7;
      if (rl != 0) lb[7] = 1'b1;
      len_bytes.push_back(lb);
    end while (rl != 0);
    // A length may carry a trailing zero group and still be valid.
    if ($urandom_range(0, 9) == 0 && len_bytes.size() < 4) begin
      lb = len_bytes.pop_back();
      lb[7] = 1'b1;
      len_bytes.push_back(lb);
      len_bytes.push_back(8'h00);
    end
    frame_buf.delete();
    frame_buf.push_back({tcode, low});
    for (i = 0; i < len_bytes.size(); i++) frame_buf.push_back(len_bytes[i]);
    for (i = 0; i < body.size(); i++) frame_buf.push_back(body[i]);
  endtask

  task automatic pick_frame();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      build_good_frame();
      if (r >= 76 && r < 82 && frame_buf.size() > 1) begin
        k = $urandom_range(1, frame_buf.size() - 1);
        while (frame_buf.size() > k) void'(frame_buf.pop_back());
      end else if (r >= 82) begin
        repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom));
      end
    end else begin
      frame_buf.delete();
      case (r % 3)
        0: begin
          frame_buf.push_back(8'($urandom));
          repeat ($urandom_range(0, 7)) frame_buf.push_back(8'($urandom));
        end
        1: begin
          frame_buf.push_back(8'($urandom));
          repeat ($urandom_range(4, 6)) frame_buf.push_back(8'h80 | 8'($urandom));
          repeat ($urandom_range(0, 2)) frame_buf.push_back(8'($urandom));
        end
        default: begin
          frame_buf.push_back($urandom_range(0, 1) ? {HDR_PUBLISH, 4'($urandom)}
                                                   : 8'($urandom));
          repeat (3) frame_buf.push_back(8'hff);
          frame_buf.push_back($urandom_range(0, 1) ? 8'h7f : 8'($urandom_range(0, 127)));
          repeat ($urandom_range(2, 6)) frame_buf.push_back(8'($urandom));
        end
      endcase
    end
  endtask

  task automatic run_phase(input logic [7:0] limit, input bit hold);
    int start;
    write_limit(limit);
    if (hold) hold_req = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick_frame();
      send_frame();
    end
    idle_on = 1'b1;
    wait_idle();
  endtask

  task automatic add_row(input logic [7:0] b, input logic last);
    stim_row_t s;
    s.rx_byte = b;
    s.frame_last = last;
    s.pinned = 1'b0;
    s.want = '0;
    directed_rows.push_back(s);
  endtask

  task automatic add_checked(input logic [7:0] b, input out_item_t want);
    stim_row_t s;
    s.rx_byte = b;
    s.frame_last = 1'b1;
    s.pinned = 1'b1;
    s.want = want;
    directed_rows.push_back(s);
  endtask

  initial begin
    int i;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      i = idle_on ? $urandom_range(0, 4) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        i = i + HOLD_CYCLES;
      end
      if (i > 0) begin
        out_ready <= 1'b0;
        repeat (i) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int i;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    topic_limit = TOPIC_LIMIT_RESET;
    ph = PH_HEADER;
    frame_count = '0;
    link_up = 1'b0;
    clear_frame();

    // The shortest well-formed frame that yields a summary.
    add_row(8'hd0, 1'b0);
    add_checked(8'h00, summary_item(KIND_PINGRESP, 16'h0, 8'h00, QOS_0, 1'b0, 28'd0,
                                    REPLY_NONE, 1'b0, 1'b0));
    add_row(8'h20, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h00, 1'b0);
    add_checked(8'h00, summary_item(KIND_CONNACK, 16'h0, 8'h00, QOS_0, 1'b0, 28'd0,
                                    REPLY_NONE, 1'b1, 1'b0));
    // Refused connection; the low nibble of the header does not change the type.
    add_row(8'h2f, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h01, 1'b0);
    add_checked(8'h05, summary_item(KIND_CONNACK, 16'h0, 8'h05, QOS_0, 1'b0, 28'd0,
                                    REPLY_NONE, 1'b0, 1'b0));
    add_row(8'h3a, 1'b0);
    add_row(8'h06, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h41, 1'b0);
    add_row(8'h12, 1'b0);
    add_row(8'h34, 1'b0);
    add_row(8'hff, 1'b1);
    // A fifth length byte makes the frame malformed.
    add_row(8'h40, 1'b0);
    repeat (4) add_row(8'h80, 1'b0);
    add_checked(8'h00, summary_item(KIND_PUBACK, 16'h0, 8'h00, QOS_0, 1'b0, 28'd0,
                                    REPLY_NONE, 1'b0, 1'b1));
    add_row(8'hf0, 1'b0);
    add_row(8'h00, 1'b1);
    // The frame ends while the length is still being decoded.
    add_row(8'h62, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h80, 1'b0);
    add_checked(8'h80, summary_item(KIND_PUBREL, 16'h0, 8'h00, QOS_0, 1'b0, 28'd0,
                                    REPLY_PUBCOMP, 1'b0, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_rows.size(); i++)
      send_byte(directed_rows[i].rx_byte, directed_rows[i].frame_last,
                directed_rows[i].pinned, directed_rows[i].want);
    wait_idle();

    run_phase(8'd0, 1'b0);
    run_phase(8'd255, 1'b1);
    run_phase(8'd3, 1'b0);
    run_phase(8'($urandom_range(1, 254)), 1'b0);

    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
